@@ rtl/triangle_unit_normal_core_defines.svh @@
// Assertion macros used by the checker file of the triangle normal core.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TUN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tun_pkg.sv @@
`default_nettype none

package tun_pkg;

    // Field and datapath widths.
    localparam int CW    = 20;          // corner coordinate
    localparam int DW    = CW + 1;      // edge vector component
    localparam int PW    = 2 * DW;      // edge product
    localparam int XW    = PW + 1;      // cross product component, signed
    localparam int MW    = XW - 1;      // cross product magnitude
    localparam int HW    = MW / 2;      // half of a magnitude for the squaring
    localparam int QSW   = 2 * MW;      // square of a magnitude
    localparam int SW    = QSW + 2;     // sum of three squares
    localparam int DDW   = 120;         // running remainder of the root search
    localparam int TW    = 104;         // running product u * s
    localparam int QW    = 15;          // magnitude of a normal component
    localparam int NW    = 16;          // normal component, Q1.14
    localparam int QSHIFT = 30;         // 2^30 scale of the squared bound

    // Pipeline layout.
    localparam int STG_DIFF = 0;
    localparam int STG_PROD = 1;
    localparam int STG_CROSS = 2;
    localparam int STG_PSQ  = 3;
    localparam int STG_SQ   = 4;
    localparam int STG_INIT = 5;
    localparam int STG_STEP = 6;
    localparam int STG_OUT  = STG_STEP + QW;
    localparam int NSTG     = STG_OUT + 1;

    // Search state of one normal component.
    typedef struct packed {
        logic signed [DDW-1:0] d;   // 2^30 c^2 - u^2 s
        logic signed [TW-1:0]  t;   // u * s with u = 2q - 1
        logic [QW-1:0]         q;
        logic                  neg;
    } comp_t;

    // Search state of one triangle.
    typedef struct packed {
        comp_t [2:0]     c;
        logic [SW-1:0]   s;
        logic            degen;
    } norm_t;

endpackage

`default_nettype wire

@@ rtl/triangle_unit_normal_core.sv @@
`default_nettype none
// Unit face normal of a triangle given by three corners in counter-clockwise order.
// Input channel: in_valid / in_stall with the nine corner coordinates (signed,
// 10 fraction bits). Output channel: out_valid / out_stall with normal_x/y/z
// (signed Q1.14, rounded to nearest) and degenerate (zero cross product, normal zero).
// A request is taken at a clock edge where valid is high and stall is low.
// One request can enter every cycle while out_stall is low. The pipeline has 22
// register stages: edge vectors, edge products, cross product, partial squares,
// squares, search setup, then one stage per result bit of the 15-bit normalizing
// root search, then the output register.
// When the receiver stalls, a stage holds only while the stage after it is full,
// so empty stages keep filling; in_stall rises once all stages hold requests.
// Reset (rst_n low, asynchronous) empties every stage; no data is cleared.
module triangle_unit_normal_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [tun_pkg::CW-1:0]      p0_x,
    input  logic signed [tun_pkg::CW-1:0]      p0_y,
    input  logic signed [tun_pkg::CW-1:0]      p0_z,
    input  logic signed [tun_pkg::CW-1:0]      p1_x,
    input  logic signed [tun_pkg::CW-1:0]      p1_y,
    input  logic signed [tun_pkg::CW-1:0]      p1_z,
    input  logic signed [tun_pkg::CW-1:0]      p2_x,
    input  logic signed [tun_pkg::CW-1:0]      p2_y,
    input  logic signed [tun_pkg::CW-1:0]      p2_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [tun_pkg::NW-1:0]      normal_x,
    output logic signed [tun_pkg::NW-1:0]      normal_y,
    output logic signed [tun_pkg::NW-1:0]      normal_z,
    output logic                               degenerate
);
    import tun_pkg::*;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] load;

    logic signed [DW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [PW-1:0] aybz_reg, azby_reg, azbx_reg, axbz_reg, axby_reg, aybx_reg;
    logic signed [XW-1:0] cr [3];
    logic [MW-1:0]        mag_reg [3];
    logic [MW-1:0]        mag_next [3];
    logic [2:0]           neg_reg, neg_psq_reg, neg_sq_reg;
    logic                 degen_reg, degen_psq_reg, degen_sq_reg;
    logic [2*HW-1:0]      hh_reg [3];
    logic [2*HW-1:0]      hl_reg [3];
    logic [2*HW-1:0]      ll_reg [3];
    logic [QSW-1:0]       sq_reg [3];
    logic [SW-1:0]        s_sum;
    norm_t                init_reg;
    norm_t                init_next;
    norm_t                chain [QW+1];
    logic [NW-1:0]        nx_reg, ny_reg, nz_reg;
    logic [NW-1:0]        nrm_next [3];
    logic                 degen_out_reg;

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        load[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (load[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (load[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall = !load[STG_DIFF];

    // Edge vectors.
    always_ff @(posedge clk)
    begin
        if (load[STG_DIFF])
        begin
            ax_reg <= DW'(p1_x) - DW'(p0_x);
            ay_reg <= DW'(p1_y) - DW'(p0_y);
            az_reg <= DW'(p1_z) - DW'(p0_z);
            bx_reg <= DW'(p2_x) - DW'(p0_x);
            by_reg <= DW'(p2_y) - DW'(p0_y);
            bz_reg <= DW'(p2_z) - DW'(p0_z);
        end
    end

    // Edge products.
    always_ff @(posedge clk)
    begin
        if (load[STG_PROD])
        begin
            aybz_reg <= ay_reg * bz_reg;
            azby_reg <= az_reg * by_reg;
            azbx_reg <= az_reg * bx_reg;
            axbz_reg <= ax_reg * bz_reg;
            axby_reg <= ax_reg * by_reg;
            aybx_reg <= ay_reg * bx_reg;
        end
    end

    // Cross product, split into sign and magnitude.
    always_comb
    begin
        cr[0] = XW'(aybz_reg) - XW'(azby_reg);
        cr[1] = XW'(azbx_reg) - XW'(axbz_reg);
        cr[2] = XW'(axby_reg) - XW'(aybx_reg);
        for (int k = 0; k < 3; k++)
        begin
            mag_next[k] = cr[k][XW-1] ? MW'(-cr[k]) : MW'(cr[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_CROSS])
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[k] <= mag_next[k];
                neg_reg[k] <= cr[k][XW-1];
            end
            degen_reg <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
        end
    end

    // Partial products of the squared magnitudes.
    always_ff @(posedge clk)
    begin
        if (load[STG_PSQ])
        begin
            for (int k = 0; k < 3; k++)
            begin
                hh_reg[k] <= mag_reg[k][MW-1:HW] * mag_reg[k][MW-1:HW];
                hl_reg[k] <= mag_reg[k][MW-1:HW] * mag_reg[k][HW-1:0];
                ll_reg[k] <= mag_reg[k][HW-1:0] * mag_reg[k][HW-1:0];
            end
            neg_psq_reg <= neg_reg;
            degen_psq_reg <= degen_reg;
        end
    end

    // Squared magnitudes.
    always_ff @(posedge clk)
    begin
        if (load[STG_SQ])
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= (QSW'(hh_reg[k]) << (2 * HW)) + (QSW'(hl_reg[k]) << (HW + 1))
                             + QSW'(ll_reg[k]);
            end
            neg_sq_reg <= neg_psq_reg;
            degen_sq_reg <= degen_psq_reg;
        end
    end

    // Search setup: q = 0, so u = -1, d = 2^30 c^2 - s and t = -s.
    always_comb
    begin
        s_sum = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        init_next.s = s_sum;
        init_next.degen = degen_sq_reg;
        for (int k = 0; k < 3; k++)
        begin
            init_next.c[k].d = (DDW'(sq_reg[k]) << QSHIFT) - DDW'(s_sum);
            init_next.c[k].t = -TW'(s_sum);
            init_next.c[k].q = '0;
            init_next.c[k].neg = neg_sq_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_INIT])
        begin
            init_reg <= init_next;
        end
    end

    assign chain[0] = init_reg;

    // One result bit per stage, most significant first.
    for (genvar g = 0; g < QW; g++)
    begin : g_step
        tun_step #(
            .BIT (QW - 1 - g)
        ) u_step (
            .clk (clk),
            .en  (load[STG_STEP + g]),
            .cur (chain[g]),
            .res (chain[g + 1])
        );
    end

    // Apply signs and force a zero normal for a degenerate triangle.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (chain[QW].degen)
            begin
                nrm_next[k] = '0;
            end
            else if (chain[QW].c[k].neg)
            begin
                nrm_next[k] = -NW'(chain[QW].c[k].q);
            end
            else
            begin
                nrm_next[k] = NW'(chain[QW].c[k].q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_OUT])
        begin
            nx_reg <= nrm_next[0];
            ny_reg <= nrm_next[1];
            nz_reg <= nrm_next[2];
            degen_out_reg <= chain[QW].degen;
        end
    end

    assign out_valid  = vld_reg[STG_OUT];
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign degenerate = degen_out_reg;

endmodule

`default_nettype wire

@@ rtl/tun_step.sv @@
`default_nettype none

module tun_step #(
    parameter int BIT = tun_pkg::QW - 1
) (
    input  logic           clk,
    input  logic           en,
    input  tun_pkg::norm_t cur,
    output tun_pkg::norm_t res
);
    import tun_pkg::*;

    norm_t res_reg;
    norm_t res_next;
    logic signed [DDW-1:0] t_sh [3];
    logic signed [DDW-1:0] s_sh;
    logic signed [DDW-1:0] cand [3];

    // Try setting bit BIT of each q: accept when (2q'-1)^2 s still fits under 2^30 c^2.
    always_comb
    begin
        res_next = cur;
        s_sh = DDW'(cur.s) << (2 * BIT + 2);
        for (int k = 0; k < 3; k++)
        begin
            t_sh[k] = DDW'(cur.c[k].t) <<< (BIT + 2);
            cand[k] = cur.c[k].d - t_sh[k] - s_sh;
            if (!cand[k][DDW-1])
            begin
                res_next.c[k].d = cand[k];
                res_next.c[k].q[BIT] = 1'b1;
                res_next.c[k].t = cur.c[k].t + (TW'(cur.s) << (BIT + 1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ rtl/tun_checker.sv @@
`default_nettype none
`include "triangle_unit_normal_core_defines.svh"

module tun_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [tun_pkg::NW-1:0] normal_x,
    input logic signed [tun_pkg::NW-1:0] normal_y,
    input logic signed [tun_pkg::NW-1:0] normal_z,
    input logic                          degenerate
);
    import tun_pkg::*;

    // A stalled result stays in place unchanged.
    `TUN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(degenerate), "stalled result changed")

    // A degenerate triangle gives the zero vector.
    `TUN_ASSERT_SAME(a_degen_zero, out_valid && degenerate, normal_x == '0 && normal_y == '0 && normal_z == '0, "degenerate normal not zero")

    // A proper triangle has a unit normal, so some component is nonzero.
    `TUN_ASSERT_SAME(a_nonzero, out_valid && !degenerate, normal_x != '0 || normal_y != '0 || normal_z != '0, "unit normal is zero")

    // Every component lies within plus or minus one in Q1.14.
    `TUN_ASSERT_SAME(a_range, out_valid, normal_x >= -16'sd16384 && normal_x <= 16'sd16384 && normal_y >= -16'sd16384 && normal_y <= 16'sd16384 && normal_z >= -16'sd16384 && normal_z <= 16'sd16384, "normal component out of range")

endmodule

bind triangle_unit_normal_core tun_checker u_tun_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
);

`default_nettype wire

@@ verif/tb_triangle_unit_normal_core.sv @@
`default_nettype none

module tb_triangle_unit_normal_core;
    import tun_pkg::*;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } corner_t;

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic                 degen;
    } normal_t;

    localparam coord_t CMAX = coord_t'(524287);
    localparam coord_t CMIN = coord_t'(-524288);

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    coord_t p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
    logic out_valid;
    logic out_stall;
    logic signed [NW-1:0] normal_x, normal_y, normal_z;
    logic degenerate;

    normal_t pending_normals[$];
    int      mismatch_count;
    int      tx_gap_max;
    int      rx_gap_max;
    int      rx_hold_cycles;

    triangle_unit_normal_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate)
    );

    // Clock with a period of two time units.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Rounded Q1.14 component: largest q with (2q-1)^2 * s <= 2^30 * c^2.
    function automatic logic signed [NW-1:0] unit_q14(longint ck, logic [127:0] s);
        logic [63:0]  mag;
        logic [159:0] bound;
        logic [159:0] scaled;
        logic [63:0]  odd;
        int lo;
        int hi;
        int mid;
        mag = (ck < 0) ? 64'(-ck) : 64'(ck);
        bound = (160'(mag) * 160'(mag)) << QSHIFT;
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            odd = 64'(2 * mid - 1);
            scaled = 160'(s) * 160'(odd * odd);
            if (scaled <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (ck < 0) ? NW'(-lo) : NW'(lo);
    endfunction

    // Face normal of one triangle, normalized cross product of its edges.
    function automatic normal_t face_normal(corner_t a, corner_t b, corner_t c);
        normal_t      n;
        longint       ex, ey, ez, fx, fy, fz, cx, cy, cz;
        logic [127:0] s;
        ex = longint'(b.x) - longint'(a.x);
        ey = longint'(b.y) - longint'(a.y);
        ez = longint'(b.z) - longint'(a.z);
        fx = longint'(c.x) - longint'(a.x);
        fy = longint'(c.y) - longint'(a.y);
        fz = longint'(c.z) - longint'(a.z);
        cx = ey * fz - ez * fy;
        cy = ez * fx - ex * fz;
        cz = ex * fy - ey * fx;
        n = '0;
        if (cx == 0 && cy == 0 && cz == 0)
        begin
            n.degen = 1'b1;
            return n;
        end
        // Squares exceed 64 bits, so they are formed at full width.
        s = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
        n.nx = unit_q14(cx, s);
        n.ny = unit_q14(cy, s);
        n.nz = unit_q14(cz, s);
        return n;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Sends one request after a random gap and records its expected normal.
    task automatic send_triangle(corner_t a, corner_t b, corner_t c);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        p0_x <= a.x; p0_y <= a.y; p0_z <= a.z;
        p1_x <= b.x; p1_y <= b.y; p1_z <= b.z;
        p2_x <= c.x; p2_y <= c.y; p2_z <= c.z;
        do
            @(posedge clk);
        while (in_stall);
        pending_normals.push_back(face_normal(a, b, c));
    endtask

    task automatic end_requests();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic coord_t rand_coord(bit wide);
        if (wide)
            return coord_t'($urandom);
        return coord_t'($urandom_range(0, 4095)) - coord_t'(2048);
    endfunction

    function automatic corner_t rand_corner(bit wide);
        corner_t p;
        p.x = rand_coord(wide);
        p.y = rand_coord(wide);
        p.z = rand_coord(wide);
        return p;
    endfunction

    // Extremes, axis-aligned faces, both windings and degenerate shapes.
    task automatic test_directed();
        corner_t o, ux, uy, uz, hi, lo, q;
        o = '0;
        ux = '{x: coord_t'(1024), y: '0, z: '0};
        uy = '{x: '0, y: coord_t'(1024), z: '0};
        uz = '{x: '0, y: '0, z: coord_t'(1024)};
        hi = '{x: CMAX, y: CMAX, z: CMAX};
        lo = '{x: CMIN, y: CMIN, z: CMIN};
        send_triangle(o, ux, uy);
        send_triangle(o, uy, ux);
        send_triangle(o, uy, uz);
        send_triangle(o, uz, uy);
        send_triangle(o, uz, ux);
        send_triangle(o, ux, uz);
        send_triangle(o, '{x: coord_t'(3), y: '0, z: '0}, '{x: '0, y: coord_t'(4), z: '0});
        send_triangle(o, '{x: coord_t'(3), y: coord_t'(4), z: '0}, uz);
        send_triangle(o, '{x: coord_t'(1), y: coord_t'(1), z: '0},
                      '{x: '0, y: coord_t'(1), z: coord_t'(1)});
        // Coincident and collinear corners give a degenerate face.
        send_triangle(o, o, o);
        send_triangle(hi, hi, hi);
        send_triangle(lo, lo, hi);
        send_triangle(lo, o, hi);
        send_triangle(o, ux, '{x: coord_t'(2048), y: '0, z: '0});
        // Full-range corners exercise the widest differences and products.
        send_triangle(lo, '{x: CMAX, y: CMIN, z: CMIN}, '{x: CMIN, y: CMAX, z: CMIN});
        send_triangle(hi, '{x: CMIN, y: CMAX, z: CMAX}, '{x: CMAX, y: CMIN, z: CMAX});
        send_triangle('{x: CMIN, y: CMAX, z: CMIN}, '{x: CMAX, y: CMIN, z: CMAX},
                      '{x: CMAX, y: CMAX, z: CMIN});
        send_triangle(o, '{x: CMAX, y: '0, z: '0}, '{x: '0, y: coord_t'(1), z: '0});
        send_triangle(o, '{x: coord_t'(1), y: '0, z: '0}, '{x: coord_t'(1), y: coord_t'(1),
                      z: CMAX});
        q = '{x: coord_t'(-1), y: coord_t'(-1), z: coord_t'(-1)};
        send_triangle(q, hi, lo);
        send_triangle(hi, lo, '{x: CMAX, y: CMIN, z: '0});
    endtask

    // Random triangles: mostly general, some degenerate, some full range.
    task automatic test_random(int count, int tx_max, int rx_max);
        corner_t a, b, c;
        int      kind;
        int      k;
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            a = rand_corner(kind >= 6);
            b = rand_corner(kind >= 6);
            c = rand_corner(kind >= 6);
            if (kind == 0)
            begin
                // Third corner on the line through the first two.
                k = $urandom_range(0, 6) - 3;
                c.x = a.x + coord_t'(k) * (b.x - a.x);
                c.y = a.y + coord_t'(k) * (b.y - a.y);
                c.z = a.z + coord_t'(k) * (b.z - a.z);
            end
            else if (kind == 1)
            begin
                b = ($urandom_range(0, 1) == 1) ? a : c;
            end
            else if (kind == 2)
            begin
                // Tiny triangles with one-unit edges.
                b = a;
                c = a;
                b.x = a.x + coord_t'($urandom_range(0, 2)) - coord_t'(1);
                c.y = a.y + coord_t'($urandom_range(0, 2)) - coord_t'(1);
                c.z = a.z + coord_t'($urandom_range(0, 2)) - coord_t'(1);
            end
            send_triangle(a, b, c);
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the pipe fills.
    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_hold_cycles = 200;
        test_random(80, 0, 0);
        rx_hold_cycles = 0;
    endtask

    // Sender pauses until every outstanding normal has arrived.
    task automatic test_drain_pause();
        end_requests();
        wait (pending_normals.size() == 0);
        test_random(30, 14, 14);
    endtask

    // Receiver: draws a stall length for every request, or holds off long.
    initial
    begin
        int gap;
        forever
        begin
            if (rx_hold_cycles > 0)
                gap = rx_hold_cycles;
            else
                gap = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compares every accepted result with the oldest expected normal.
    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_normals.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                want = pending_normals.pop_front();
                if (normal_x !== want.nx)
                    report_mismatch("normal_x", normal_x, want.nx);
                if (normal_y !== want.ny)
                    report_mismatch("normal_y", normal_y, want.ny);
                if (normal_z !== want.nz)
                    report_mismatch("normal_z", normal_z, want.nz);
                if (degenerate !== want.degen)
                    report_mismatch("degenerate", degenerate, want.degen);
            end
        end
    end

    // Run limit.
    initial
    begin
        #800000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_cycles = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        {p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(300, 0, 0);
        test_random(400, 14, 14);
        test_random(200, 3, 14);
        test_random(220, 14, 2);
        end_requests();
        wait (pending_normals.size() == 0);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/tun_pkg.sv
rtl/tun_step.sv
rtl/triangle_unit_normal_core.sv
rtl/tun_checker.sv
verif/tb_triangle_unit_normal_core.sv
